@@ rtl/ssm_pkg.sv @@
package ssm_pkg;

    // Default line buffer capacity in bytes.
    localparam int LINE_CAP_DEF = 32;

    // Configuration port geometry and register indexes.
    localparam int REG_AW = 5;
    localparam int REG_DW = 32;
    localparam logic [2:0] REG_TIMEOUT     = 3'd0;
    localparam logic [2:0] REG_CLEAN_SOL   = 3'd1;
    localparam logic [2:0] REG_CLEAN_TOTAL = 3'd2;
    localparam logic [2:0] REG_WATER_HOLD  = 3'd3;
    localparam logic [2:0] REG_BLINK       = 3'd4;
    localparam logic [2:0] REG_YELLOW      = 3'd5;
    localparam logic [2:0] REG_RED         = 3'd6;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RST     = 16'd30000;
    localparam logic [15:0] CLEAN_SOL_RST   = 16'd3000;
    localparam logic [15:0] CLEAN_TOTAL_RST = 16'd5000;
    localparam logic [15:0] WATER_HOLD_RST  = 16'd3000;
    localparam logic [7:0]  BLINK_RST       = 8'd125;
    localparam logic [6:0]  YELLOW_RST      = 7'd50;
    localparam logic [6:0]  RED_RST         = 7'd90;

    // Segment patterns, bit 0 is segment a.
    localparam logic [6:0] SEG_DASH = 7'h40;
    localparam logic [6:0] SEG_C    = 7'h39;
    localparam logic [6:0] SEG_L    = 7'h38;
    localparam logic [6:0] SEG_E    = 7'h79;
    localparam logic [6:0] SEG_N    = 7'h54;
    localparam logic [6:0] SEG_ZERO = 7'h3F;

    // Character codes used by the line parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Command keywords, first character in the top byte.
    localparam logic [47:0] KW_PILLS = "PILLS:";
    localparam logic [71:0] KW_PROG  = "PROGRESS:";
    localparam logic [63:0] KW_WATER = "WATER:HI";
    localparam int KW_PILLS_LEN = 6;
    localparam int KW_PROG_LEN  = 9;
    localparam int KW_WATER_LEN = 8;

    // Candidate keyword bits.
    localparam int CAND_PILLS = 0;
    localparam int CAND_PROG  = 1;
    localparam int CAND_WATER = 2;

    // Number limits.
    localparam logic [9:0] NUM_MAX   = 10'd1023;
    localparam logic [9:0] PILLS_MAX = 10'd999;
    localparam logic [9:0] PROG_MAX  = 10'd100;
    localparam logic [6:0] PROG_FULL = 7'd100;

    // Status lamp codes.
    localparam logic [2:0] LAMP_OFF    = 3'b000;
    localparam logic [2:0] LAMP_GREEN  = 3'b001;
    localparam logic [2:0] LAMP_YELLOW = 3'b010;
    localparam logic [2:0] LAMP_RED    = 3'b100;

    typedef enum logic [2:0] {
        MODE_RUN     = 3'b001,
        MODE_CLEAN   = 3'b010,
        MODE_TIMEOUT = 3'b100
    } run_mode_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [15:0] clean_solenoid_ms;
        logic [15:0] clean_total_ms;
        logic [15:0] water_hold_ms;
        logic [7:0]  blink_ticks;
        logic [6:0]  yellow_from;
        logic [6:0]  red_from;
    } cfg_t;

    // Command decoded at the end of a line.
    typedef struct packed {
        logic       set_pills;
        logic       set_prog;
        logic       set_water;
        logic [9:0] value;
    } line_cmd_t;

    typedef struct packed {
        logic [6:0] seg0;
        logic [6:0] seg1;
        logic [6:0] seg2;
        logic [6:0] seg3;
        logic [2:0] lamps;
        logic       blue;
        logic       solenoid;
        logic       packaging;
        logic       send_reset;
    } result_t;

    // Keyword characters by position; zero past the end of the keyword.
    function automatic logic [7:0] pills_char(input logic [3:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        if (int'(idx) < KW_PILLS_LEN) begin
            c = KW_PILLS[8*(KW_PILLS_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] prog_char(input logic [3:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        if (int'(idx) < KW_PROG_LEN) begin
            c = KW_PROG[8*(KW_PROG_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] water_char(input logic [3:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        if (int'(idx) < KW_WATER_LEN) begin
            c = KW_WATER[8*(KW_WATER_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [6:0] seg_of_digit(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Quotient by 100 for values up to 999, by reciprocal 41/4096.
    function automatic logic [3:0] div100(input logic [9:0] v);
        logic [15:0] prod;
        prod = 16'(v) * 16'd41;
        return prod[15:12];
    endfunction

    // Two digit segment pair for 0..99, tens in the upper half.
    function automatic logic [13:0] seg_pair(input logic [6:0] r);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(r) * 15'd205;
        tens = prod[14:11];
        ones = r - 7'(tens) * 7'd10;
        return {seg_of_digit(tens), seg_of_digit(ones[3:0])};
    endfunction

endpackage

@@ rtl/serial_status_monitor_controller_core.sv @@
// Serial status monitor and controller.
// Input channel (s_valid/s_ready): one request per event, s_mode 0 for a received
// UART byte in s_rx_byte, s_mode 1 for a one millisecond tick. Result channel
// (m_valid/m_ready): exactly one result per request, in order, carrying the four
// seven-segment digits, the status lamps, the blue blink level, the solenoid and
// packaging drives and a one-result send_reset pulse when a clean sequence starts.
// Throughput is one request per cycle while the receiver keeps up. A request is
// taken into an input register and processed into the result register once that
// register is free or draining. The input register keeps accepting while a
// result waits; when the receiver stalls, the result holds, the input register
// fills and s_ready falls until m_ready returns.
// The APB port holds the timing and threshold registers at byte address 4*i;
// write them only while no request is in flight.
// Reset (aresetn low, synchronous) empties both registers, loads the register
// defaults, returns the controller to run mode with all counters cleared and
// restarts line parsing.
module serial_status_monitor_controller_core
    import ssm_pkg::*;
#(
    parameter int LINE_CAP = LINE_CAP_DEF
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_seg_digit0,
    output logic [6:0]        m_seg_digit1,
    output logic [6:0]        m_seg_digit2,
    output logic [6:0]        m_seg_digit3,
    output logic              m_led_green,
    output logic              m_led_yellow,
    output logic              m_led_red,
    output logic              m_led_blue,
    output logic              m_solenoid,
    output logic              m_packaging,
    output logic              m_send_reset,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [REG_AW-1:0] paddr,
    input  logic [REG_DW-1:0] pwdata,
    output logic [REG_DW-1:0] prdata,
    output logic              pready
);

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       fire;
    logic       byte_fire;
    cfg_t       cfg;
    line_cmd_t  cmd;
    result_t    res;

    // Advance when a request waits and the result register is free or draining.
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign byte_fire = fire && !in_mode_reg;
    assign s_ready   = !in_valid_reg || fire;

    ssm_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssm_line_parser #(
        .LINE_CAP (LINE_CAP)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (in_byte_reg),
        .cmd       (cmd)
    );

    ssm_mode_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ev_fire (fire),
        .ev_tick (in_mode_reg),
        .cfg     (cfg),
        .cmd     (cmd),
        .res     (res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_seg_digit0 = out_reg.seg0;
    assign m_seg_digit1 = out_reg.seg1;
    assign m_seg_digit2 = out_reg.seg2;
    assign m_seg_digit3 = out_reg.seg3;
    assign m_led_green  = out_reg.lamps[0];
    assign m_led_yellow = out_reg.lamps[1];
    assign m_led_red    = out_reg.lamps[2];
    assign m_led_blue   = out_reg.blue;
    assign m_solenoid   = out_reg.solenoid;
    assign m_packaging  = out_reg.packaging;
    assign m_send_reset = out_reg.send_reset;

endmodule

@@ rtl/ssm_apb_regs.sv @@
module ssm_apb_regs
    import ssm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [REG_AW-1:0] paddr,
    input  logic [REG_DW-1:0] pwdata,
    output logic [REG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[REG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms        <= TIMEOUT_RST;
            cfg_reg.clean_solenoid_ms <= CLEAN_SOL_RST;
            cfg_reg.clean_total_ms    <= CLEAN_TOTAL_RST;
            cfg_reg.water_hold_ms     <= WATER_HOLD_RST;
            cfg_reg.blink_ticks       <= BLINK_RST;
            cfg_reg.yellow_from       <= YELLOW_RST;
            cfg_reg.red_from          <= RED_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TIMEOUT:     cfg_reg.timeout_ms        <= pwdata[15:0];
                REG_CLEAN_SOL:   cfg_reg.clean_solenoid_ms <= pwdata[15:0];
                REG_CLEAN_TOTAL: cfg_reg.clean_total_ms    <= pwdata[15:0];
                REG_WATER_HOLD:  cfg_reg.water_hold_ms     <= pwdata[15:0];
                REG_BLINK:       cfg_reg.blink_ticks       <= pwdata[7:0];
                REG_YELLOW:      cfg_reg.yellow_from       <= pwdata[6:0];
                REG_RED:         cfg_reg.red_from          <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            REG_TIMEOUT:     prdata = REG_DW'(cfg_reg.timeout_ms);
            REG_CLEAN_SOL:   prdata = REG_DW'(cfg_reg.clean_solenoid_ms);
            REG_CLEAN_TOTAL: prdata = REG_DW'(cfg_reg.clean_total_ms);
            REG_WATER_HOLD:  prdata = REG_DW'(cfg_reg.water_hold_ms);
            REG_BLINK:       prdata = REG_DW'(cfg_reg.blink_ticks);
            REG_YELLOW:      prdata = REG_DW'(cfg_reg.yellow_from);
            REG_RED:         prdata = REG_DW'(cfg_reg.red_from);
            default:         prdata = '0;
        endcase
    end

endmodule

@@ rtl/ssm_line_parser.sv @@
module ssm_line_parser
    import ssm_pkg::*;
#(
    parameter int LINE_CAP = LINE_CAP_DEF
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_fire,
    input  logic [7:0] rx_byte,
    output line_cmd_t  cmd
);

    localparam int LW = $clog2(LINE_CAP);
    localparam logic [LW-1:0] LEN_LAST  = LW'(LINE_CAP - 1);
    localparam logic [LW-1:0] LEN_PILLS = LW'(KW_PILLS_LEN);
    localparam logic [LW-1:0] LEN_PROG  = LW'(KW_PROG_LEN);
    localparam logic [LW-1:0] LEN_WATER = LW'(KW_WATER_LEN);

    logic [LW-1:0] len_reg, len_next;
    logic [2:0]    alive_reg, alive_next;
    logic [9:0]    num_reg, num_next;
    logic          neg_reg, neg_next;
    logic          started_reg, started_next;
    logic          closed_reg, closed_next;

    logic [2:0]  feed_alive;
    logic [9:0]  feed_num;
    logic        feed_neg, feed_started, feed_closed;
    logic        num_take, is_space, is_sign, is_digit;
    logic [13:0] digit_sum;
    logic        p_hit, g_hit, w_hit, num_ok;

    assign is_space = (rx_byte == CH_SP) || (rx_byte == CH_TAB) ||
                      (rx_byte == CH_VT) || (rx_byte == CH_FF);
    assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
    assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign digit_sum = 14'(num_reg) * 14'd10 + 14'(rx_byte - CH_0);

    // Feed one byte: prune keyword candidates, then step the number scanner.
    always_comb begin
        feed_alive   = alive_reg;
        feed_num     = num_reg;
        feed_neg     = neg_reg;
        feed_started = started_reg;
        feed_closed  = closed_reg;
        if (alive_reg[CAND_PILLS] && len_reg < LEN_PILLS &&
            rx_byte != pills_char(len_reg[3:0])) begin
            feed_alive[CAND_PILLS] = 1'b0;
        end
        if (alive_reg[CAND_PROG] && len_reg < LEN_PROG &&
            rx_byte != prog_char(len_reg[3:0])) begin
            feed_alive[CAND_PROG] = 1'b0;
        end
        if (alive_reg[CAND_WATER] && len_reg < LEN_WATER &&
            rx_byte != water_char(len_reg[3:0])) begin
            feed_alive[CAND_WATER] = 1'b0;
        end
        // Anything but a terminating zero after WATER:HI spoils the match.
        if (feed_alive[CAND_WATER] && len_reg >= LEN_WATER && rx_byte != CH_NUL) begin
            feed_alive[CAND_WATER] = 1'b0;
        end
        num_take = (feed_alive[CAND_PILLS] && len_reg >= LEN_PILLS) ||
                   (feed_alive[CAND_PROG] && len_reg >= LEN_PROG);
        if (num_take) begin
            if (!started_reg && is_space) begin
                feed_started = started_reg;
            end else if (!started_reg && is_sign) begin
                feed_started = 1'b1;
                feed_neg     = (rx_byte == CH_MINUS) ? 1'b1 : neg_reg;
            end else if (is_digit) begin
                feed_started = 1'b1;
                feed_num     = (digit_sum > 14'(NUM_MAX)) ? NUM_MAX : digit_sum[9:0];
            end else begin
                feed_closed = 1'b1;
            end
        end
        if (rx_byte == CH_NUL) begin
            feed_closed = 1'b1;
        end
    end

    // Line bookkeeping for one accepted byte.
    always_comb begin
        len_next     = len_reg;
        alive_next   = alive_reg;
        num_next     = num_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        closed_next  = closed_reg;
        if (byte_fire && rx_byte != CH_CR) begin
            if (rx_byte == CH_LF || len_reg >= LEN_LAST) begin
                len_next     = '0;
                alive_next   = 3'b111;
                num_next     = '0;
                neg_next     = 1'b0;
                started_next = 1'b0;
                closed_next  = 1'b0;
            end else begin
                if (!closed_reg) begin
                    alive_next   = feed_alive;
                    num_next     = feed_num;
                    neg_next     = feed_neg;
                    started_next = feed_started;
                    closed_next  = feed_closed;
                end
                len_next = len_reg + LW'(1);
            end
        end
    end

    // Decode the finished line on a line feed.
    assign num_ok = !neg_reg || (num_reg == '0);
    assign p_hit  = alive_reg[CAND_PILLS] && (len_reg >= LEN_PILLS);
    assign g_hit  = alive_reg[CAND_PROG] && (len_reg >= LEN_PROG);
    assign w_hit  = alive_reg[CAND_WATER] && (len_reg >= LEN_WATER);

    always_comb begin
        cmd.set_pills = 1'b0;
        cmd.set_prog  = 1'b0;
        cmd.set_water = 1'b0;
        cmd.value     = num_reg;
        if (byte_fire && rx_byte == CH_LF) begin
            if (p_hit) begin
                cmd.set_pills = num_ok && (num_reg <= PILLS_MAX);
            end else if (g_hit) begin
                cmd.set_prog = num_ok && (num_reg <= PROG_MAX);
            end else begin
                cmd.set_water = w_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            alive_reg   <= 3'b111;
            num_reg     <= '0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            closed_reg  <= 1'b0;
        end else begin
            len_reg     <= len_next;
            alive_reg   <= alive_next;
            num_reg     <= num_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            closed_reg  <= closed_next;
        end
    end

endmodule

@@ rtl/ssm_mode_ctrl.sv @@
module ssm_mode_ctrl
    import ssm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      ev_fire,
    input  logic      ev_tick,
    input  cfg_t      cfg,
    input  line_cmd_t cmd,
    output result_t   res
);

    run_mode_t   mode_reg, mode_next;
    logic [9:0]  pills_reg, pills_next;
    logic [6:0]  prog_reg, prog_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] water_reg, water_next;
    logic [7:0]  blink_reg, blink_next;
    logic        blue_reg, blue_next;
    logic [2:0]  lamps_reg, lamps_next;
    logic [1:0]  drive_reg, drive_next;

    logic        timed_out;
    logic [3:0]  p_hund;
    logic [6:0]  p_rem, g_rem;
    logic [13:0] p_segs, g_segs;

    // Counters and line commands first, then the mode decision on the new values.
    always_comb begin
        mode_next    = mode_reg;
        pills_next   = pills_reg;
        prog_next    = prog_reg;
        idle_next    = idle_reg;
        elapsed_next = elapsed_reg;
        water_next   = water_reg;
        blink_next   = blink_reg;
        blue_next    = blue_reg;
        lamps_next   = lamps_reg;
        drive_next   = drive_reg;
        res.seg0       = SEG_DASH;
        res.seg1       = SEG_DASH;
        res.seg2       = SEG_DASH;
        res.seg3       = SEG_DASH;
        res.send_reset = 1'b0;
        p_hund = '0;
        p_rem  = '0;
        g_rem  = '0;
        p_segs = '0;
        g_segs = '0;

        if (ev_tick) begin
            if (idle_reg != 16'hFFFF) begin
                idle_next = idle_reg + 16'd1;
            end
            if (mode_reg == MODE_CLEAN && elapsed_reg != 16'hFFFF) begin
                elapsed_next = elapsed_reg + 16'd1;
            end
            if (water_reg != '0) begin
                water_next = water_reg - 16'd1;
            end
            if (blink_reg >= cfg.blink_ticks) begin
                blue_next  = ~blue_reg;
                blink_next = '0;
            end else begin
                blink_next = blink_reg + 8'd1;
            end
        end else begin
            idle_next = '0;
            if (cmd.set_pills) begin
                pills_next = cmd.value;
            end
            if (cmd.set_prog) begin
                prog_next = cmd.value[6:0];
            end
            if (cmd.set_water) begin
                water_next = cfg.water_hold_ms;
            end
        end

        timed_out = idle_next > cfg.timeout_ms;

        if (timed_out || mode_reg == MODE_TIMEOUT) begin
            // Dashes and red; a byte that ends the silence still shows this once.
            lamps_next = LAMP_RED;
            mode_next  = timed_out ? MODE_TIMEOUT : MODE_RUN;
        end else begin
            case (mode_reg)
                MODE_CLEAN: begin
                    drive_next = {elapsed_next < cfg.clean_total_ms,
                                  elapsed_next < cfg.clean_solenoid_ms};
                    res.seg0   = SEG_C;
                    res.seg1   = SEG_L;
                    res.seg2   = SEG_E;
                    res.seg3   = SEG_N;
                    lamps_next = LAMP_OFF;
                    if (elapsed_next >= cfg.clean_total_ms) begin
                        mode_next  = MODE_RUN;
                        pills_next = '0;
                        prog_next  = '0;
                        drive_next = '0;
                        lamps_next = LAMP_GREEN;
                        res.seg0   = SEG_ZERO;
                        res.seg1   = SEG_ZERO;
                        res.seg2   = SEG_ZERO;
                        res.seg3   = SEG_ZERO;
                    end
                end
                default: begin
                    // Run display: last two digits of pills and of progress.
                    p_hund = div100(pills_next);
                    p_rem  = 7'(pills_next - 10'(p_hund) * 10'd100);
                    g_rem  = (prog_next >= PROG_FULL) ? prog_next - PROG_FULL : prog_next;
                    p_segs = seg_pair(p_rem);
                    g_segs = seg_pair(g_rem);
                    res.seg0 = p_segs[13:7];
                    res.seg1 = p_segs[6:0];
                    res.seg2 = g_segs[13:7];
                    res.seg3 = g_segs[6:0];
                    if (prog_next < cfg.yellow_from) begin
                        lamps_next = LAMP_GREEN;
                    end else if (prog_next < cfg.red_from) begin
                        lamps_next = LAMP_YELLOW;
                    end else if (prog_next < PROG_FULL) begin
                        lamps_next = LAMP_RED;
                    end
                    if (prog_next >= PROG_FULL) begin
                        mode_next      = MODE_CLEAN;
                        elapsed_next   = '0;
                        res.send_reset = 1'b1;
                    end
                end
            endcase
        end

        res.lamps     = lamps_next;
        res.blue      = blue_next;
        res.solenoid  = drive_next[0] || (water_next != '0);
        res.packaging = drive_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_RUN;
            pills_reg   <= '0;
            prog_reg    <= '0;
            idle_reg    <= '0;
            elapsed_reg <= '0;
            water_reg   <= '0;
            blink_reg   <= '0;
            blue_reg    <= 1'b0;
            lamps_reg   <= LAMP_OFF;
            drive_reg   <= '0;
        end else if (ev_fire) begin
            mode_reg    <= mode_next;
            pills_reg   <= pills_next;
            prog_reg    <= prog_next;
            idle_reg    <= idle_next;
            elapsed_reg <= elapsed_next;
            water_reg   <= water_next;
            blink_reg   <= blink_next;
            blue_reg    <= blue_next;
            lamps_reg   <= lamps_next;
            drive_reg   <= drive_next;
        end
    end

endmodule

@@ rtl/ssm_checker.sv @@
module ssm_checker
    import ssm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [6:0]        m_seg_digit0,
    input logic [6:0]        m_seg_digit1,
    input logic [6:0]        m_seg_digit2,
    input logic [6:0]        m_seg_digit3,
    input logic              m_led_green,
    input logic              m_led_yellow,
    input logic              m_led_red,
    input logic              m_led_blue,
    input logic              m_solenoid,
    input logic              m_packaging,
    input logic              m_send_reset
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_seg_digit0, m_seg_digit1, m_seg_digit2, m_seg_digit3,
                     m_led_green, m_led_yellow, m_led_red, m_led_blue,
                     m_solenoid, m_packaging, m_send_reset}))
        else $error("result changed while stalled");

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input backpressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // Timeout display is all dashes with the red lamp.
    a_timeout_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_seg_digit0 == SEG_DASH |->
            m_seg_digit1 == SEG_DASH && m_seg_digit2 == SEG_DASH &&
            m_seg_digit3 == SEG_DASH && m_led_red)
        else $error("partial timeout display");

    // A clean start comes from full progress, shown as zero in the last two digits.
    a_clean_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_reset |-> m_seg_digit2 == SEG_ZERO && m_seg_digit3 == SEG_ZERO)
        else $error("reset request without full progress");

endmodule

bind serial_status_monitor_controller_core ssm_checker u_ssm_checker (.*);

@@ verif/testbench.sv @@
module testbench;
    import ssm_pkg::*;

    // Cycles with no request and no result moving before the run is abandoned.
    localparam int STALL_LIMIT = 4000;
    // Random requests per register setting.
    localparam int PHASE_ITEMS = 225;
    localparam int PHASES      = 6;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } serial_event_t;

    typedef enum {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_pattern_t;

    // Predicts the display, lamps and drives after every event, and checks them.
    class panel_predictor;
        // Register copies.
        logic [15:0] timeout_ms;
        logic [15:0] clean_sol_ms;
        logic [15:0] clean_total_ms;
        logic [15:0] water_hold_ms;
        logic [7:0]  blink_ticks;
        logic [6:0]  yellow_from;
        logic [6:0]  red_from;

        // Controller state.
        run_mode_t   mode_q;
        logic [9:0]  pills;
        logic [6:0]  progress;
        logic [15:0] idle_ms;
        logic [15:0] clean_ms;
        logic [15:0] water_ms;
        logic [7:0]  blink_cnt;
        logic        blue;
        logic [2:0]  lamps;
        logic [1:0]  drive;

        // Line parser state.
        int          line_len;
        logic [2:0]  alive;
        int          num_val;
        logic        num_neg;
        logic        num_started;
        logic        num_closed;

        logic [6:0]  seg_table[10];
        string       kw_pills = "PILLS:";
        string       kw_prog  = "PROGRESS:";
        string       kw_water = "WATER:HI";

        result_t     panel_expected[$];
        int          errors;
        int          events_noted;
        int          results_seen;
        int          cleans_started;
        int          timeout_shown;

        function new();
            timeout_ms     = TIMEOUT_RST;
            clean_sol_ms   = CLEAN_SOL_RST;
            clean_total_ms = CLEAN_TOTAL_RST;
            water_hold_ms  = WATER_HOLD_RST;
            blink_ticks    = BLINK_RST;
            yellow_from    = YELLOW_RST;
            red_from       = RED_RST;
            mode_q    = MODE_RUN;
            pills     = '0;
            progress  = '0;
            idle_ms   = '0;
            clean_ms  = '0;
            water_ms  = '0;
            blink_cnt = '0;
            blue      = 1'b0;
            lamps     = LAMP_OFF;
            drive     = 2'b00;
            seg_table = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                          7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
            errors = 0;
            events_noted = 0;
            results_seen = 0;
            cleans_started = 0;
            timeout_shown = 0;
            clear_line();
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_TIMEOUT:     timeout_ms     = value[15:0];
                REG_CLEAN_SOL:   clean_sol_ms   = value[15:0];
                REG_CLEAN_TOTAL: clean_total_ms = value[15:0];
                REG_WATER_HOLD:  water_hold_ms  = value[15:0];
                REG_BLINK:       blink_ticks    = value[7:0];
                REG_YELLOW:      yellow_from    = value[6:0];
                REG_RED:         red_from       = value[6:0];
                default: ;
            endcase
        endfunction

        function void clear_line();
            line_len    = 0;
            alive       = 3'b111;
            num_val     = 0;
            num_neg     = 1'b0;
            num_started = 1'b0;
            num_closed  = 1'b0;
        endfunction

        // Number text after a keyword: blanks, one sign, then digits.
        function void feed_number(logic [7:0] b);
            if (!num_started && (b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF))
                return;
            if (!num_started && (b == CH_PLUS || b == CH_MINUS)) begin
                num_started = 1'b1;
                if (b == CH_MINUS)
                    num_neg = 1'b1;
                return;
            end
            if (b >= CH_0 && b <= CH_9) begin
                num_started = 1'b1;
                num_val = num_val * 10 + int'(b - CH_0);
                if (num_val > 1023)
                    num_val = 1023;
                return;
            end
            num_closed = 1'b1;
        endfunction

        // Narrow the keyword candidates and feed the number once a prefix matched.
        function void feed_line(logic [7:0] b);
            int p;
            p = line_len;
            if (num_closed)
                return;
            if (alive[CAND_PILLS] && p < kw_pills.len() && b != kw_pills[p])
                alive[CAND_PILLS] = 1'b0;
            if (alive[CAND_PROG] && p < kw_prog.len() && b != kw_prog[p])
                alive[CAND_PROG] = 1'b0;
            if (alive[CAND_WATER] && p < kw_water.len() && b != kw_water[p])
                alive[CAND_WATER] = 1'b0;
            if (alive[CAND_WATER] && p >= kw_water.len() && b != CH_NUL)
                alive[CAND_WATER] = 1'b0;
            if ((alive[CAND_PILLS] && p >= kw_pills.len()) ||
                (alive[CAND_PROG] && p >= kw_prog.len()))
                feed_number(b);
            if (b == CH_NUL)
                num_closed = 1'b1;
        endfunction

        // Act on a complete line.
        function void finish_line();
            bit ok;
            ok = !num_neg || num_val == 0;
            if (alive[CAND_PILLS] && line_len >= kw_pills.len()) begin
                if (ok && num_val <= 999)
                    pills = 10'(num_val);
            end else if (alive[CAND_PROG] && line_len >= kw_prog.len()) begin
                if (ok && num_val <= 100)
                    progress = 7'(num_val);
            end else if (alive[CAND_WATER] && line_len >= kw_water.len()) begin
                water_ms = water_hold_ms;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            idle_ms = '0;
            if (b == CH_CR)
                return;
            if (b == CH_LF) begin
                finish_line();
                clear_line();
                return;
            end
            // A full buffer drops the byte and restarts the line.
            if (line_len >= LINE_CAP_DEF - 1) begin
                clear_line();
                return;
            end
            feed_line(b);
            line_len++;
        endfunction

        function void take_tick();
            if (idle_ms != 16'hFFFF)
                idle_ms++;
            if (mode_q == MODE_CLEAN && clean_ms != 16'hFFFF)
                clean_ms++;
            if (water_ms != 0)
                water_ms--;
            if (blink_cnt >= blink_ticks) begin
                blue = ~blue;
                blink_cnt = '0;
            end else begin
                blink_cnt++;
            end
        endfunction

        // One accepted request: update the state and queue the expected panel.
        function void note_event(logic mode, logic [7:0] data);
            result_t r;
            int left, right;
            logic send;
            send = 1'b0;
            events_noted++;
            if (!mode)
                take_byte(data);
            else
                take_tick();

            if (idle_ms > timeout_ms)
                mode_q = MODE_TIMEOUT;

            case (mode_q)
                MODE_TIMEOUT: begin
                    r.seg0 = SEG_DASH;
                    r.seg1 = SEG_DASH;
                    r.seg2 = SEG_DASH;
                    r.seg3 = SEG_DASH;
                    lamps = LAMP_RED;
                    timeout_shown++;
                    if (idle_ms <= timeout_ms)
                        mode_q = MODE_RUN;
                end
                MODE_CLEAN: begin
                    drive = {clean_ms < clean_total_ms, clean_ms < clean_sol_ms};
                    r.seg0 = SEG_C;
                    r.seg1 = SEG_L;
                    r.seg2 = SEG_E;
                    r.seg3 = SEG_N;
                    lamps = LAMP_OFF;
                    if (clean_ms >= clean_total_ms) begin
                        mode_q = MODE_RUN;
                        pills = '0;
                        progress = '0;
                        drive = 2'b00;
                        lamps = LAMP_GREEN;
                        r.seg0 = SEG_ZERO;
                        r.seg1 = SEG_ZERO;
                        r.seg2 = SEG_ZERO;
                        r.seg3 = SEG_ZERO;
                    end
                end
                default: begin
                    left  = int'(pills) % 100;
                    right = int'(progress) % 100;
                    r.seg0 = seg_table[left / 10];
                    r.seg1 = seg_table[left % 10];
                    r.seg2 = seg_table[right / 10];
                    r.seg3 = seg_table[right % 10];
                    // At full progress the lamps keep their last levels.
                    if (progress < yellow_from)
                        lamps = LAMP_GREEN;
                    else if (progress < red_from)
                        lamps = LAMP_YELLOW;
                    else if (progress < PROG_FULL)
                        lamps = LAMP_RED;
                    if (progress >= PROG_FULL) begin
                        mode_q = MODE_CLEAN;
                        clean_ms = '0;
                        send = 1'b1;
                        cleans_started++;
                    end
                end
            endcase

            r.lamps      = lamps;
            r.blue       = blue;
            r.solenoid   = drive[0] || water_ms != 0;
            r.packaging  = drive[1];
            r.send_reset = send;
            panel_expected.push_back(r);
        endfunction

        function void compare_field(string field, logic [6:0] want, logic [6:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 60)
                    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, field, want, got);
            end
        endfunction

        // One accepted result against the oldest expected panel.
        function void check_panel(result_t got);
            result_t want;
            if (panel_expected.size() == 0) begin
                errors++;
                $display("%0t: result 0x%0h arrived with no request outstanding",
                         $time, got);
                return;
            end
            want = panel_expected.pop_front();
            results_seen++;
            compare_field("seg_digit0", want.seg0, got.seg0);
            compare_field("seg_digit1", want.seg1, got.seg1);
            compare_field("seg_digit2", want.seg2, got.seg2);
            compare_field("seg_digit3", want.seg3, got.seg3);
            compare_field("led_green", 7'(want.lamps[0]), 7'(got.lamps[0]));
            compare_field("led_yellow", 7'(want.lamps[1]), 7'(got.lamps[1]));
            compare_field("led_red", 7'(want.lamps[2]), 7'(got.lamps[2]));
            compare_field("led_blue", 7'(want.blue), 7'(got.blue));
            compare_field("solenoid", 7'(want.solenoid), 7'(got.solenoid));
            compare_field("packaging", 7'(want.packaging), 7'(got.packaging));
            compare_field("send_reset", 7'(want.send_reset), 7'(got.send_reset));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_mode;
    logic [7:0]        s_rx_byte;
    logic              m_valid;
    logic              m_ready;
    logic [6:0]        m_seg_digit0;
    logic [6:0]        m_seg_digit1;
    logic [6:0]        m_seg_digit2;
    logic [6:0]        m_seg_digit3;
    logic              m_led_green;
    logic              m_led_yellow;
    logic              m_led_red;
    logic              m_led_blue;
    logic              m_solenoid;
    logic              m_packaging;
    logic              m_send_reset;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [REG_AW-1:0] paddr;
    logic [REG_DW-1:0] pwdata;
    logic [REG_DW-1:0] prdata;
    logic              pready;

    panel_predictor panel;
    serial_event_t  serial_queue[$];
    int             stall_cycles = 0;

    serial_status_monitor_controller_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_seg_digit0 (m_seg_digit0),
        .m_seg_digit1 (m_seg_digit1),
        .m_seg_digit2 (m_seg_digit2),
        .m_seg_digit3 (m_seg_digit3),
        .m_led_green  (m_led_green),
        .m_led_yellow (m_led_yellow),
        .m_led_red    (m_led_red),
        .m_led_blue   (m_led_blue),
        .m_solenoid   (m_solenoid),
        .m_packaging  (m_packaging),
        .m_send_reset (m_send_reset),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock with a period of 8.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Both channels are sampled at the rising edge; requests are noted before results.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else begin
            if (s_valid && s_ready)
                panel.note_event(s_mode, s_rx_byte);
            if (m_valid && m_ready)
                panel.check_panel({m_seg_digit0, m_seg_digit1, m_seg_digit2, m_seg_digit3,
                                   m_led_red, m_led_yellow, m_led_green, m_led_blue,
                                   m_solenoid, m_packaging, m_send_reset});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Ends the run when nothing has moved for too long.
    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("** serial_status_monitor_controller_core: FAILED **");
        $finish;
    end

    // Result side: changing stall patterns plus a long hold-off now and then.
    initial begin : receiver
        rx_pattern_t pattern;
        int span;
        int since_hold;
        m_ready = 1'b0;
        since_hold = 600;
        @(negedge aclk);
        while (!aresetn)
            @(negedge aclk);
        forever begin
            pattern = rx_pattern_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                case (pattern)
                    RX_ALWAYS:    m_ready = 1'b1;
                    RX_HALF:      m_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE:    m_ready = ($urandom_range(0, 3) == 0);
                    RX_ALTERNATE: m_ready = ~m_ready;
                    default:      m_ready = 1'b1;
                endcase
                @(negedge aclk);
            end
            since_hold += span;
            // Long hold-off so the block fills up and stalls its input.
            if (since_hold >= 900) begin
                since_hold = 0;
                m_ready = 1'b0;
                repeat (120) @(negedge aclk);
            end
        end
    end

    function automatic void push_byte(logic [7:0] b);
        serial_queue.push_back({1'b0, b});
    endfunction

    function automatic void push_tick(logic [7:0] b);
        serial_queue.push_back({1'b1, b});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    // A keyword line with a number in assorted spellings.
    function automatic void push_number_line(string kw, int value);
        int blanks;
        int sign_pick;
        int pad;
        int tail;
        push_text(kw);
        blanks = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (blanks) begin
            case ($urandom_range(0, 3))
                0:       push_byte(CH_SP);
                1:       push_byte(CH_TAB);
                2:       push_byte(CH_VT);
                default: push_byte(CH_FF);
            endcase
        end
        sign_pick = $urandom_range(0, 9);
        if (sign_pick == 8)
            push_byte(CH_PLUS);
        else if (sign_pick == 9)
            push_byte(CH_MINUS);
        // Now and then no digits at all.
        if ($urandom_range(0, 15) != 0) begin
            pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            repeat (pad) push_byte(CH_0);
            push_text($sformatf("%0d", value));
        end
        tail = $urandom_range(0, 9);
        if (tail == 0) begin
            push_byte(8'($urandom_range(0, 255)));
        end else if (tail == 1) begin
            push_byte(CH_NUL);
            push_byte(CH_0 + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0)
            push_byte(CH_CR);
        push_byte(CH_LF);
    endfunction

    // Queue one random sequence: ticks, a command line, noise or a line near the buffer capacity.
    function automatic void make_sequence();
        int pick;
        int len;
        int pos;
        int value;
        string kw;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if (panel.timeout_ms < 100)
                len = $urandom_range(1, int'(panel.timeout_ms) + 4);
            else
                len = $urandom_range(1, 30);
            repeat (len) push_tick(8'($urandom_range(0, 255)));
        end else if (pick < 48) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = 100;
                4:          value = int'(panel.yellow_from);
                5:          value = int'(panel.red_from);
                6:          value = $urandom_range(101, 150);
                default:    value = $urandom_range(0, 99);
            endcase
            push_number_line("PROGRESS:", value);
        end else if (pick < 64) begin
            case ($urandom_range(0, 7))
                0:       value = 999;
                1:       value = 1000;
                2:       value = 1023;
                3:       value = $urandom_range(1024, 999999);
                4:       value = $urandom_range(0, 99);
                default: value = $urandom_range(0, 999);
            endcase
            push_number_line("PILLS:", value);
        end else if (pick < 72) begin
            case ($urandom_range(0, 4))
                0: push_text("WATER:HI");
                1: begin
                    push_text("WATER:HI");
                    push_byte(CH_CR);
                end
                2: begin
                    push_text("WATER:HI");
                    push_byte(CH_NUL);
                    push_byte(8'($urandom_range(1, 255)));
                end
                3: push_text("WATER:HIX");
                default: push_text("WATER:H");
            endcase
            push_byte(CH_LF);
        end else if (pick < 80) begin
            // A keyword with one byte replaced.
            case ($urandom_range(0, 2))
                0:       kw = "PILLS:";
                1:       kw = "PROGRESS:";
                default: kw = "WATER:HI";
            endcase
            pos = $urandom_range(0, kw.len() - 1);
            for (int i = 0; i < kw.len(); i++)
                push_byte(i == pos ? 8'($urandom_range(0, 255)) : kw[i]);
            push_text("42");
            push_byte(CH_LF);
        end else if (pick < 92) begin
            len = $urandom_range(1, 8);
            repeat (len) push_byte(8'($urandom_range(0, 255)));
        end else begin
            // Around the line buffer capacity.
            len = $urandom_range(LINE_CAP_DEF - 3, LINE_CAP_DEF + 6);
            push_text("PILLS:");
            repeat (len - 6) push_byte(CH_0 + 8'($urandom_range(0, 9)));
            push_byte(CH_LF);
        end
    endfunction

    // Send requests in bursts with gaps, refilling the queue as it runs dry.
    task automatic play(input int count);
        int sent;
        int burst;
        int gap;
        serial_event_t ev;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                if (serial_queue.size() == 0)
                    make_sequence();
                ev = serial_queue.pop_front();
                s_valid   = 1'b1;
                s_mode    = ev.mode;
                s_rx_byte = ev.data;
                do @(posedge aclk); while (!s_ready);
                @(negedge aclk);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid = 1'b0;
        @(negedge aclk);
    endtask

    // Setup and access cycles; psel stays high across back-to-back writes.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        panel.set_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic configure(input int tmo, input int sol, input int total, input int water,
                             input int blink, input int yellow, input int red);
        reg_write(REG_TIMEOUT, 32'(tmo));
        reg_write(REG_CLEAN_SOL, 32'(sol));
        reg_write(REG_CLEAN_TOTAL, 32'(total));
        reg_write(REG_WATER_HOLD, 32'(water));
        reg_write(REG_BLINK, 32'(blink));
        reg_write(REG_YELLOW, 32'(yellow));
        reg_write(REG_RED, 32'(red));
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        while (panel.panel_expected.size() != 0)
            @(negedge aclk);
    endtask

    // Main sequence: reset, directed requests, then one random phase per setting.
    initial begin : stimulus
        panel     = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_mode    = 1'b0;
        s_rx_byte = 8'h00;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Field extremes, a zero byte, a carriage return, negative zero and the water hold.
        push_tick(8'hFF);
        push_tick(8'h00);
        push_byte(CH_NUL);
        push_byte(8'hFF);
        push_byte(CH_LF);
        push_text("PILLS: -0");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_text("WATER:HI");
        push_byte(CH_LF);
        play(serial_queue.size());

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: ;
                1: configure(20, 8, 30, 6, 0, 0, 100);
                2: configure(1, 0, 1, 0, 255, 100, 0);
                3: configure(65534, 65535, 65535, 65535, 3, 30, 70);
                default: configure($urandom_range(4, 60), $urandom_range(0, 25),
                                   $urandom_range(1, 40), $urandom_range(0, 20),
                                   $urandom_range(0, 12), $urandom_range(0, 100),
                                   $urandom_range(0, 100));
            endcase
            play(PHASE_ITEMS);
        end

        drain();
        repeat (4) @(posedge aclk);

        $display("Run covered %0d serial events and ticks, %0d results, %0d register settings.",
                 panel.events_noted, panel.results_seen, PHASES);
        $display("Clean sequences started: %0d, timeout panels shown: %0d, mismatches: %0d.",
                 panel.cleans_started, panel.timeout_shown, panel.errors);
        if (panel.errors == 0 && panel.panel_expected.size() == 0) begin
            $display("** serial_status_monitor_controller_core: PASSED **");
        end else begin
            $display("** serial_status_monitor_controller_core: FAILED **");
        end
        $finish;
    end

endmodule
